// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every edge outside reset.
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on the edge right after reset is applied.
`define ASSERT_AFTER_RST(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) (!(rstn)) |=> (prop)) else $error(msg);

`endif

// ----- src/sttab_pkg.sv -----
package sttab_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int KEY_BITS    = 16;

    localparam int KEY_W         = 16;
    localparam int DUE_BITS      = 31;
    localparam int SLOT_KEY_BITS = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int SLOT_IDX_BITS = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_BITS      = $clog2(TIMER_SLOTS + 1);

    localparam logic [DUE_BITS-1:0] DUE_MAX = '1;

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_POLL  = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [KEY_W-1:0]    timer_key;
        logic [DUE_BITS-1:0] delay;
        logic [DUE_BITS-1:0] repeat_interval;
        logic [DUE_BITS-1:0] now;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]    fired_key;
        logic                fired_valid;
        logic                last;
        logic [DUE_BITS-1:0] next_due;
        logic                any_pending;
        logic [DUE_BITS-1:0] wait_time;
        logic                status;
    } out_item_t;

    typedef struct packed {
        logic                     valid;
        logic                     fired;
        logic [SLOT_KEY_BITS-1:0] key;
        logic [DUE_BITS-1:0]      due;
        logic [DUE_BITS-1:0]      ivl;
    } slot_t;

    typedef struct packed {
        logic [1:0]               action;
        logic                     hit;
        logic [SLOT_KEY_BITS-1:0] key;
        logic [DUE_BITS-1:0]      now;
        logic [DUE_BITS-1:0]      new_due;
        logic [DUE_BITS-1:0]      new_ivl;
    } head_ctrl_t;

    function automatic logic [DUE_BITS-1:0] sat_add(input logic [DUE_BITS-1:0] a,
                                                    input logic [DUE_BITS-1:0] b);
        logic [DUE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DUE_BITS] ? DUE_MAX : s[DUE_BITS-1:0];
    endfunction

endpackage

// ----- src/sttab_cell.sv -----
module sttab_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              shift,
    input  sttab_pkg::slot_t                  d_in,
    input  logic [sttab_pkg::SLOT_KEY_BITS-1:0] cmp_key,
    output sttab_pkg::slot_t                  q,
    output logic                              match
);

    sttab_pkg::slot_t slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
            slot_reg.fired <= 1'b0;
        end else if (shift) begin
            slot_reg <= d_in;
        end
    end

    assign q     = slot_reg;
    assign match = slot_reg.valid && (slot_reg.key == cmp_key);

endmodule

// ----- src/sttab_head.sv -----
module sttab_head (
    input  sttab_pkg::head_ctrl_t ctrl,
    input  sttab_pkg::slot_t      head_in,
    output sttab_pkg::slot_t      head_out,
    output logic                  fire
);

    logic                              expired;
    logic [sttab_pkg::DUE_BITS-1:0]    reload_due;

    assign expired    = head_in.valid && (head_in.due <= ctrl.now);
    assign reload_due = sttab_pkg::sat_add(head_in.due, head_in.ivl);

    always_comb begin
        head_out       = head_in;
        head_out.fired = 1'b0;
        fire           = 1'b0;
        case (ctrl.action)
            sttab_pkg::ACT_SET: begin
                if (ctrl.hit) begin
                    head_out.valid = 1'b1;
                    head_out.key   = ctrl.key;
                    head_out.due   = ctrl.new_due;
                    head_out.ivl   = ctrl.new_ivl;
                end
            end
            sttab_pkg::ACT_CLEAR: begin
                if (head_in.valid && (head_in.key == ctrl.key)) begin
                    head_out.valid = 1'b0;
                end
            end
            sttab_pkg::ACT_TICK: begin
                if (expired) begin
                    fire           = 1'b1;
                    head_out.fired = 1'b1;
                    if (head_in.ivl != '0) begin
                        head_out.due = reload_due;
                    end else begin
                        head_out.valid = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- src/software_timer_table.sv -----
// Timer table of TIMER_SLOTS slots held in a ring of cells that rotates past one shared
// update unit at its head. Set, clear and tick each take one full rotation of the ring,
// during which the earliest due time is folded from the ring tail, then a response
// state loads the result. A tick that fires timers takes a second rotation of the ring
// that hands out one fired key per firing slot in ascending slot order, stretched by
// any stall on m_ready. A poll needs no rotation and goes straight to the response
// state. s_ready is high only between items; a result may still wait in the output
// register while the next item is taken. Slot valid bits clear on reset, so the table
// is usable on the next cycle.
`include "assert_macros.svh"

module software_timer_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sttab_pkg::in_item_t   s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sttab_pkg::out_item_t  m_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [sttab_pkg::CNT_BITS-1:0] CNT_FULL =
        sttab_pkg::CNT_BITS'(sttab_pkg::TIMER_SLOTS);
    localparam logic [sttab_pkg::CNT_BITS-1:0] CNT_LAST =
        sttab_pkg::CNT_BITS'(sttab_pkg::TIMER_SLOTS - 1);

    logic [1:0]                          state_reg, state_next;
    logic [sttab_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;
    sttab_pkg::in_item_t                 req_reg, req_next;
    logic [sttab_pkg::DUE_BITS-1:0]      new_due_reg, new_due_next;
    logic [sttab_pkg::SLOT_IDX_BITS-1:0] target_reg, target_next;
    logic                                has_target_reg, has_target_next;
    logic [sttab_pkg::CNT_BITS-1:0]      fire_cnt_reg, fire_cnt_next;
    logic [sttab_pkg::CNT_BITS-1:0]      emit_cnt_reg, emit_cnt_next;
    logic [sttab_pkg::DUE_BITS-1:0]      min_reg, min_next;
    logic                                min_found_reg, min_found_next;
    logic [sttab_pkg::DUE_BITS-1:0]      earliest_reg, earliest_next;
    logic                                pending_reg, pending_next;
    logic                                m_valid_reg, m_valid_next;
    sttab_pkg::out_item_t                m_item_reg, m_item_next;

    sttab_pkg::slot_t                    ring_q [sttab_pkg::TIMER_SLOTS];
    sttab_pkg::slot_t                    tail_in;
    sttab_pkg::slot_t                    head_upd;
    sttab_pkg::head_ctrl_t               head_ctrl;
    logic                                head_fire;
    logic                                shift;
    logic [sttab_pkg::TIMER_SLOTS-1:0]   match_vec;
    logic [sttab_pkg::TIMER_SLOTS-1:0]   valid_vec;
    logic [sttab_pkg::TIMER_SLOTS-1:0]   pick_vec;
    logic [sttab_pkg::SLOT_IDX_BITS-1:0] pick_idx;
    logic                                fold_found;
    logic [sttab_pkg::DUE_BITS-1:0]      fold_min;
    logic [sttab_pkg::DUE_BITS-1:0]      wait_val;
    logic                                status_bit;
    logic                                out_load;
    logic                                can_load;
    sttab_pkg::out_item_t                out_item;

    genvar gi;
    generate
        for (gi = 0; gi < sttab_pkg::TIMER_SLOTS; gi++) begin : g_cell
            sttab_pkg::slot_t cell_d;
            if (gi == sttab_pkg::TIMER_SLOTS - 1) begin : g_tail
                assign cell_d = tail_in;
            end else begin : g_mid
                assign cell_d = ring_q[gi + 1];
            end
            sttab_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (shift),
                .d_in    (cell_d),
                .cmp_key (s_item.timer_key[sttab_pkg::SLOT_KEY_BITS-1:0]),
                .q       (ring_q[gi]),
                .match   (match_vec[gi])
            );
            assign valid_vec[gi] = ring_q[gi].valid;
        end
    endgenerate

    assign head_ctrl.action  = req_reg.action;
    assign head_ctrl.hit     = (req_reg.action == sttab_pkg::ACT_SET) && has_target_reg &&
                               (cnt_reg[sttab_pkg::SLOT_IDX_BITS-1:0] == target_reg);
    assign head_ctrl.key     = req_reg.timer_key[sttab_pkg::SLOT_KEY_BITS-1:0];
    assign head_ctrl.now     = req_reg.now;
    assign head_ctrl.new_due = new_due_reg;
    assign head_ctrl.new_ivl = req_reg.repeat_interval;

    sttab_head u_head (
        .ctrl     (head_ctrl),
        .head_in  (ring_q[0]),
        .head_out (head_upd),
        .fire     (head_fire)
    );

    assign pick_vec = (|match_vec) ? match_vec : ~valid_vec;

    always_comb begin
        pick_idx = '0;
        for (int i = sttab_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
            if (pick_vec[i]) begin
                pick_idx = sttab_pkg::SLOT_IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        fold_found = min_found_reg;
        fold_min   = min_reg;
        if (ring_q[sttab_pkg::TIMER_SLOTS-1].valid &&
            (!min_found_reg || (ring_q[sttab_pkg::TIMER_SLOTS-1].due < min_reg))) begin
            fold_found = 1'b1;
            fold_min   = ring_q[sttab_pkg::TIMER_SLOTS-1].due;
        end
    end

    assign wait_val   = (pending_reg && (earliest_reg > req_reg.now)) ?
                        (earliest_reg - req_reg.now) : '0;
    assign status_bit = (req_reg.action == sttab_pkg::ACT_SET) && !has_target_reg;
    assign can_load   = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        new_due_next    = new_due_reg;
        target_next     = target_reg;
        has_target_next = has_target_reg;
        fire_cnt_next   = fire_cnt_reg;
        emit_cnt_next   = emit_cnt_reg;
        min_next        = min_reg;
        min_found_next  = min_found_reg;
        earliest_next   = earliest_reg;
        pending_next    = pending_reg;
        shift           = 1'b0;
        tail_in         = head_upd;
        out_load        = 1'b0;

        out_item             = '0;
        out_item.last        = 1'b1;
        out_item.next_due    = earliest_reg;
        out_item.any_pending = pending_reg;
        out_item.wait_time   = wait_val;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next        = s_item;
                    new_due_next    = sttab_pkg::sat_add(s_item.now, s_item.delay);
                    target_next     = pick_idx;
                    has_target_next = |pick_vec;
                    cnt_next        = '0;
                    fire_cnt_next   = '0;
                    emit_cnt_next   = '0;
                    min_found_next  = 1'b0;
                    state_next      = (s_item.action == sttab_pkg::ACT_POLL) ?
                                      ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg != CNT_FULL) begin
                    shift   = 1'b1;
                    tail_in = head_upd;
                    if (head_fire) begin
                        fire_cnt_next = fire_cnt_reg + 1'b1;
                    end
                end
                if (cnt_reg != '0) begin
                    min_next       = fold_min;
                    min_found_next = fold_found;
                end
                if (cnt_reg == CNT_FULL) begin
                    earliest_next = fold_found ? fold_min : '0;
                    pending_next  = fold_found;
                    cnt_next      = '0;
                    state_next    = ((req_reg.action == sttab_pkg::ACT_TICK) &&
                                     (fire_cnt_reg != '0)) ? ST_EMIT : ST_RESP;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESP: begin
                if (can_load) begin
                    out_load        = 1'b1;
                    out_item.status = status_bit;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                tail_in = ring_q[0];
                if (ring_q[0].fired) begin
                    if (can_load) begin
                        out_load             = 1'b1;
                        out_item.fired_key   = sttab_pkg::KEY_W'(ring_q[0].key);
                        out_item.fired_valid = 1'b1;
                        out_item.last        = ((emit_cnt_reg + 1'b1) == fire_cnt_reg);
                        emit_cnt_next        = emit_cnt_reg + 1'b1;
                        shift                = 1'b1;
                    end
                end else begin
                    shift = 1'b1;
                end
                if (shift) begin
                    if (cnt_reg == CNT_LAST) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = out_load || (m_valid_reg && !m_ready);
        m_item_next  = out_load ? out_item : m_item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fire_cnt_reg  <= '0;
            emit_cnt_reg  <= '0;
            min_found_reg <= 1'b0;
            earliest_reg  <= '0;
            pending_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fire_cnt_reg  <= fire_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            min_found_reg <= min_found_next;
            earliest_reg  <= earliest_next;
            pending_reg   <= pending_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        new_due_reg    <= new_due_next;
        target_reg     <= target_next;
        has_target_reg <= has_target_next;
        min_reg        <= min_next;
        m_item_reg     <= m_item_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `ASSERT_AFTER_RST(a_rst_quiet, aclk, aresetn, !m_valid && s_ready, "not idle after reset")
    `ASSERT_CLK(a_accept_busy, aclk, aresetn, (s_valid && s_ready) |=> (state_reg != ST_IDLE),
        "item accepted but block stayed idle")
    `ASSERT_CLK(a_emit_bound, aclk, aresetn, emit_cnt_reg <= fire_cnt_reg,
        "more fired keys sent than timers fired")
    `ASSERT_CLK(a_not_last_fired, aclk, aresetn, (m_valid && !m_item.last) |-> m_item.fired_valid,
        "non-final transfer without a fired key")
    `ASSERT_CLK(a_full_status, aclk, aresetn, (out_load && out_item.status) |-> (&valid_vec),
        "table full reported with a free slot")

endmodule

// ----- tb/tb_software_timer_table.sv -----
`timescale 1ns / 100ps

module tb_software_timer_table;

    class timer_scoreboard;
        bit                             armed [sttab_pkg::TIMER_SLOTS];
        logic [sttab_pkg::KEY_W-1:0]    armed_key [sttab_pkg::TIMER_SLOTS];
        logic [sttab_pkg::DUE_BITS-1:0] due_at [sttab_pkg::TIMER_SLOTS];
        logic [sttab_pkg::DUE_BITS-1:0] period [sttab_pkg::TIMER_SLOTS];
        logic [sttab_pkg::DUE_BITS-1:0] soonest = '0;
        sttab_pkg::out_item_t           awaited_results [$];
        int                             mismatches = 0;

        function logic [sttab_pkg::DUE_BITS-1:0] clamp_sum(logic [sttab_pkg::DUE_BITS-1:0] a,
                                                           logic [sttab_pkg::DUE_BITS-1:0] b);
            logic [sttab_pkg::DUE_BITS:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s > {1'b0, sttab_pkg::DUE_MAX}) return sttab_pkg::DUE_MAX;
            return s[sttab_pkg::DUE_BITS-1:0];
        endfunction

        function void refresh_soonest();
            bit found;
            found = 1'b0;
            soonest = '0;
            for (int i = 0; i < sttab_pkg::TIMER_SLOTS; i++) begin
                if (armed[i] && (!found || due_at[i] < soonest)) begin
                    soonest = due_at[i];
                    found = 1'b1;
                end
            end
        endfunction

        function void push_result(logic [sttab_pkg::KEY_W-1:0] key, logic fired, logic fin,
                                  logic [sttab_pkg::DUE_BITS-1:0] now, logic full);
            sttab_pkg::out_item_t r;
            bit                   pend;
            pend = 1'b0;
            for (int i = 0; i < sttab_pkg::TIMER_SLOTS; i++) pend |= armed[i];
            r.fired_key   = key;
            r.fired_valid = fired;
            r.last        = fin;
            r.next_due    = pend ? soonest : '0;
            r.any_pending = pend;
            r.wait_time   = (pend && soonest > now) ? soonest - now : '0;
            r.status      = full;
            awaited_results.insert(awaited_results.size(), r);
        endfunction

        function void note_request(sttab_pkg::in_item_t it);
            int                          slot;
            logic [sttab_pkg::KEY_W-1:0] fired_keys [$];
            slot = -1;
            for (int i = 0; i < sttab_pkg::TIMER_SLOTS; i++)
                if (armed[i] && armed_key[i] == it.timer_key) slot = i;
            case (it.action)
                sttab_pkg::ACT_SET: begin
                    for (int i = 0; i < sttab_pkg::TIMER_SLOTS; i++)
                        if (slot < 0 && !armed[i]) slot = i;
                    if (slot >= 0) begin
                        armed[slot]     = 1'b1;
                        armed_key[slot] = it.timer_key;
                        due_at[slot]    = clamp_sum(it.now, it.delay);
                        period[slot]    = it.repeat_interval;
                    end
                    refresh_soonest();
                    push_result('0, 1'b0, 1'b1, it.now, slot < 0);
                end
                sttab_pkg::ACT_CLEAR: begin
                    if (slot >= 0) armed[slot] = 1'b0;
                    refresh_soonest();
                    push_result('0, 1'b0, 1'b1, it.now, 1'b0);
                end
                sttab_pkg::ACT_TICK: begin
                    for (int i = 0; i < sttab_pkg::TIMER_SLOTS; i++) begin
                        if (armed[i] && due_at[i] <= it.now) begin
                            fired_keys.insert(fired_keys.size(), armed_key[i]);
                            if (period[i] != 0) due_at[i] = clamp_sum(due_at[i], period[i]);
                            else armed[i] = 1'b0;
                        end
                    end
                    refresh_soonest();
                    if (fired_keys.size() == 0) push_result('0, 1'b0, 1'b1, it.now, 1'b0);
                    foreach (fired_keys[k])
                        push_result(fired_keys[k], 1'b1, k == fired_keys.size() - 1, it.now,
                                    1'b0);
                end
                sttab_pkg::ACT_POLL: begin
                    push_result('0, 1'b0, 1'b1, it.now, 1'b0);
                end
                default: begin
                end
            endcase
        endfunction

        function string describe(sttab_pkg::out_item_t r);
            return $sformatf("key=%h fv=%b last=%b due=%h pend=%b wait=%h st=%b",
                             r.fired_key, r.fired_valid, r.last, r.next_due,
                             r.any_pending, r.wait_time, r.status);
        endfunction

        function void check_response(sttab_pkg::out_item_t got);
            sttab_pkg::out_item_t want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing awaited: %s", describe(got));
                return;
            end
            want = awaited_results.pop_front();
            if (got.fired_key !== want.fired_key || got.fired_valid !== want.fired_valid ||
                got.last !== want.last || got.next_due !== want.next_due ||
                got.any_pending !== want.any_pending || got.wait_time !== want.wait_time ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t\n  want %s\n  got  %s",
                             $time, describe(want), describe(got));
            end
        endfunction
    endclass

    logic                 aclk    = 0;
    logic                 aresetn = 0;
    logic                 s_valid = 0;
    sttab_pkg::in_item_t  s_item  = '0;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_ready = 0;
    sttab_pkg::out_item_t m_item;

    int sender_idle_pct   = 25;
    int receiver_idle_pct = 66;

    timer_scoreboard                sb;
    logic [sttab_pkg::KEY_W-1:0]    key_pool [24];
    logic [sttab_pkg::DUE_BITS-1:0] uptime;

    software_timer_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_response(m_item);
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic sttab_pkg::in_item_t make_item(logic [1:0] action,
                                                      logic [sttab_pkg::KEY_W-1:0] key,
                                                      logic [sttab_pkg::DUE_BITS-1:0] delay,
                                                      logic [sttab_pkg::DUE_BITS-1:0] ivl,
                                                      logic [sttab_pkg::DUE_BITS-1:0] now);
        sttab_pkg::in_item_t it;
        it.action          = action;
        it.timer_key       = key;
        it.delay           = delay;
        it.repeat_interval = ivl;
        it.now             = now;
        return it;
    endfunction

    task automatic issue(sttab_pkg::in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(it);
    endtask

    initial begin
        sttab_pkg::in_item_t            it;
        int                             pick;
        logic [sttab_pkg::DUE_BITS-1:0] delay;
        logic [sttab_pkg::DUE_BITS-1:0] ivl;
        logic [sttab_pkg::DUE_BITS:0]   stepped;

        sb = new;
        for (int i = 0; i < 24; i++) key_pool[i] = sttab_pkg::KEY_W'($urandom);
        key_pool[0]  = 16'h0000;
        key_pool[15] = 16'hFFFF;
        for (int i = 1; i < 15; i++) key_pool[i] = sttab_pkg::KEY_W'(16'h0100 + i * 16'h0111);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        issue(make_item(sttab_pkg::ACT_POLL, '0, '0, '0, '0));
        issue(make_item(sttab_pkg::ACT_TICK, 16'hFFFF, sttab_pkg::DUE_MAX, sttab_pkg::DUE_MAX,
                        sttab_pkg::DUE_MAX));
        // fill every slot: zero due time, saturated due, one-shot and periodic mix
        issue(make_item(sttab_pkg::ACT_SET, key_pool[0], '0, '0, '0));
        for (int i = 1; i < 15; i++)
            issue(make_item(sttab_pkg::ACT_SET, key_pool[i], sttab_pkg::DUE_BITS'(6 * i),
                            (i % 4 == 0) ? '0 :
                            ((i == 5) ? sttab_pkg::DUE_MAX : sttab_pkg::DUE_BITS'(i)),
                            sttab_pkg::DUE_BITS'(i)));
        issue(make_item(sttab_pkg::ACT_SET, key_pool[15], sttab_pkg::DUE_MAX, 31'd1,
                        sttab_pkg::DUE_MAX));
        issue(make_item(sttab_pkg::ACT_SET, 16'h5555, 31'd10, 31'd0, 31'd20));
        issue(make_item(sttab_pkg::ACT_SET, key_pool[0], 31'd3, 31'd2, 31'd1));
        issue(make_item(sttab_pkg::ACT_TICK, '0, '0, '0, 31'd50));
        issue(make_item(sttab_pkg::ACT_TICK, '0, '0, '0, 31'd50));
        issue(make_item(sttab_pkg::ACT_CLEAR, 16'hFFFF, '0, '0, 31'd55));
        issue(make_item(sttab_pkg::ACT_CLEAR, 16'hAAAA, '0, '0, 31'd56));
        issue(make_item(sttab_pkg::ACT_TICK, '0, '0, '0, sttab_pkg::DUE_MAX));
        issue(make_item(sttab_pkg::ACT_TICK, '0, '0, '0, sttab_pkg::DUE_MAX));
        issue(make_item(sttab_pkg::ACT_POLL, '0, '0, '0, sttab_pkg::DUE_MAX));

        uptime = '0;
        for (int k = 0; k < 200; k++) begin
            if (k == 67) begin
                sender_idle_pct   = 66;
                receiver_idle_pct = 25;
            end else if (k == 134) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end

            pick = $urandom_range(19);
            if (pick == 0) begin
                uptime = sttab_pkg::DUE_BITS'($urandom);
            end else if (pick == 1) begin
                uptime = sttab_pkg::DUE_BITS'($urandom_range(0, 100));
            end else begin
                stepped = {1'b0, uptime} + $urandom_range(0, 30);
                uptime  = (stepped > {1'b0, sttab_pkg::DUE_MAX}) ? sttab_pkg::DUE_MAX :
                          stepped[sttab_pkg::DUE_BITS-1:0];
            end

            pick = $urandom_range(9);
            if (pick < 7) delay = sttab_pkg::DUE_BITS'($urandom_range(0, 80));
            else if (pick < 9) delay = sttab_pkg::DUE_BITS'($urandom);
            else delay = sttab_pkg::DUE_MAX - sttab_pkg::DUE_BITS'($urandom_range(0, 3));

            pick = $urandom_range(19);
            if (pick < 8) ivl = '0;
            else if (pick < 17) ivl = sttab_pkg::DUE_BITS'($urandom_range(1, 50));
            else ivl = sttab_pkg::DUE_BITS'($urandom);

            it = make_item(sttab_pkg::ACT_POLL, key_pool[$urandom_range(23)], delay, ivl,
                           uptime);
            if ($urandom_range(9) == 0) it.timer_key = sttab_pkg::KEY_W'($urandom);

            pick = $urandom_range(99);
            if (pick < 35) it.action = sttab_pkg::ACT_SET;
            else if (pick < 50) it.action = sttab_pkg::ACT_CLEAR;
            else if (pick < 85) it.action = sttab_pkg::ACT_TICK;
            issue(it);
        end
        s_valid <= 1'b0;

        while (sb.awaited_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
